FILE: hw/rtl/ddtq_pkg.sv
// ----------------------------------------------------------------------------
// ddtq_pkg
// Shared widths, status codes and the table entry type of the tick queue.
// ----------------------------------------------------------------------------
package ddtq_pkg;

  localparam int unsigned DL_W  = 64;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned SRC_W = 3;
  localparam int unsigned ST_W  = 3;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned INDEX_COUNT  = 4096;
  localparam int unsigned SOURCE_COUNT = 8;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_KEPT     = 3'd1;
  localparam logic [ST_W-1:0] ST_REPLACED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_DUE      = 3'd4;
  localparam logic [ST_W-1:0] ST_NONE     = 3'd5;

  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [IDX_W-1:0] index;
    logic [SRC_W-1:0] source;
  } entry_t;

endpackage

FILE: hw/rtl/ddtq_table.sv
// ----------------------------------------------------------------------------
// ddtq_table
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ddtq_table import ddtq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/deduplicating_deadline_tick_queue_unit.sv
// ----------------------------------------------------------------------------
// deduplicating_deadline_tick_queue_unit
// Sorted, deduplicated table of pending ticks with schedule and pop.
// ----------------------------------------------------------------------------
// One input channel (in_valid_i / in_ready_o) carries schedule or pop beats;
// one output channel (out_valid_o / out_ready_i) carries result beats, the
// final one of each input marked by last_o. The block takes one input beat at
// a time and drops in_ready_o until its work on the table is done.
// All work runs through the table (one read port, one write port) with one
// deadline comparator; each beat is accepted in idle, then:
//   schedule: unless the beat is out of range, scan for a match and the insert
//     position; unless the entry is kept or the table is full, shift entries
//     up to open the slot and write the new one; then load the output register.
//   pop: scan for due entries, read and emit each due entry in turn through
//     the output register, then shift the remaining entries down (a single
//     none result when nothing is due).
// The output register holds a result while the receiver stalls; the
// sequencer waits on it and resumes when it is taken.
// Reset clears the entry count and the control state at once; the table
// contents need no clearing pass.
// ----------------------------------------------------------------------------
module deduplicating_deadline_tick_queue_unit import ddtq_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             operation_i,
  input  logic [IDX_W-1:0] block_index_i,
  input  logic [DL_W-1:0]  deadline_i,
  input  logic [SRC_W-1:0] source_i,
  input  logic [DL_W-1:0]  now_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ST_W-1:0]  status_o,
  output logic [IDX_W-1:0] out_index_o,
  output logic [SRC_W-1:0] out_source_o,
  output logic [DL_W-1:0]  out_deadline_o,
  output logic             last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHUP  = 3'd2;
  localparam logic [2:0] S_PSCAN = 3'd3;
  localparam logic [2:0] S_PRD   = 3'd4;
  localparam logic [2:0] S_PWR   = 3'd5;
  localparam logic [2:0] S_SHDN  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             chk_v_q, chk_v_d;
  logic [CW-1:0]    chk_pos_q, chk_pos_d;
  logic             wv_q, wv_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             pfound_q, pfound_d;
  logic [CW-1:0]    dcnt_q, dcnt_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic [DL_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [SRC_W-1:0] src_q, src_d;

  logic             out_valid_q;
  logic             out_load;
  logic [ST_W-1:0]  out_st;
  entry_t           out_ent;
  logic             out_last;
  logic             out_free;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  entry_t           wr_data, rd_data;

  logic             le, key_match, out_of_range, stop;
  logic [CW-1:0]    ptr_inc, ptr_dec, ptr_sub, p_eff;

  ddtq_table #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // shared deadline comparator: entry deadline against the new deadline or now
  assign le        = rd_data.deadline <= key_q;
  assign key_match = (rd_data.index == idx_q) && (rd_data.source == src_q);
  assign ptr_inc   = ptr_q + 1'b1;
  assign ptr_dec   = ptr_q - 1'b1;
  assign ptr_sub   = ptr_q - dcnt_q;
  assign p_eff     = pfound_q ? pos_q : chk_pos_q;
  assign stop      = chk_v_q && !le;
  assign out_free  = !out_valid_q || out_ready_i;

  assign out_of_range = ({{(32-IDX_W){1'b0}}, block_index_i} >= 32'(INDEX_COUNT)) ||
                        ({{(32-SRC_W){1'b0}}, source_i} >= 32'(SOURCE_COUNT));

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    chk_v_d   = chk_v_q;
    chk_pos_d = chk_pos_q;
    wv_d      = wv_q;
    wa_d      = wa_q;
    pos_d     = pos_q;
    pfound_d  = pfound_q;
    dcnt_d    = dcnt_q;
    status_d  = status_q;
    key_d     = key_q;
    idx_d     = idx_q;
    src_d     = src_q;
    rd_en     = 1'b0;
    rd_addr   = ptr_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = wa_q;
    wr_data   = rd_data;
    out_load  = 1'b0;
    out_st    = status_q;
    out_ent   = '0;
    out_last  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d    = operation_i ? now_i : deadline_i;
          idx_d    = block_index_i;
          src_d    = source_i;
          ptr_d    = '0;
          chk_v_d  = 1'b0;
          pfound_d = 1'b0;
          pos_d    = '0;
          dcnt_d   = '0;
          wv_d     = 1'b0;
          if (operation_i) begin
            state_d = S_PSCAN;
          end else if (out_of_range) begin
            status_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        chk_v_d = 1'b0;
        if (ptr_q != count_q) begin
          rd_en     = 1'b1;
          ptr_d     = ptr_inc;
          chk_v_d   = 1'b1;
          chk_pos_d = ptr_q;
        end
        if (chk_v_q) begin
          if (!pfound_q && !le) begin
            pfound_d = 1'b1;
            pos_d    = chk_pos_q;
          end
          if (key_match) begin
            chk_v_d = 1'b0;
            if (le) begin
              status_d = ST_KEPT;
              state_d  = S_RESP;
            end else begin
              status_d = ST_REPLACED;
              pos_d    = p_eff;
              ptr_d    = chk_pos_q;
              wv_d     = 1'b0;
              state_d  = S_SHUP;
            end
          end
        end else if (ptr_q == count_q) begin
          if (count_q == CW'(CAPACITY)) begin
            status_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            status_d = ST_INSERTED;
            pos_d    = pfound_q ? pos_q : count_q;
            ptr_d    = count_q;
            count_d  = count_q + 1'b1;
            wv_d     = 1'b0;
            state_d  = S_SHUP;
          end
        end
      end

      S_SHUP: begin
        wv_d = 1'b0;
        if (wv_q) begin
          wr_en   = 1'b1;
          wr_addr = wa_q;
          wr_data = rd_data;
        end
        if (ptr_q != pos_q) begin
          rd_en   = 1'b1;
          rd_addr = ptr_dec[AW-1:0];
          ptr_d   = ptr_dec;
          wv_d    = 1'b1;
          wa_d    = ptr_q[AW-1:0];
        end else if (!wv_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q[AW-1:0];
          wr_data = '{deadline: key_q, index: idx_q, source: src_q};
          state_d = S_RESP;
        end
      end

      S_PSCAN: begin
        chk_v_d = 1'b0;
        if (ptr_q != count_q) begin
          rd_en     = 1'b1;
          ptr_d     = ptr_inc;
          chk_v_d   = 1'b1;
          chk_pos_d = ptr_q;
        end
        if (chk_v_q && le) begin
          dcnt_d = chk_pos_q + 1'b1;
        end
        if (stop || (!chk_v_q && ptr_q == count_q)) begin
          chk_v_d = 1'b0;
          ptr_d   = '0;
          if (dcnt_q == '0) begin
            status_d = ST_NONE;
            state_d  = S_RESP;
          end else begin
            state_d = S_PRD;
          end
        end
      end

      S_PRD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_q[AW-1:0];
        state_d = S_PWR;
      end

      S_PWR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_st   = ST_DUE;
          out_ent  = rd_data;
          out_last = (ptr_inc == dcnt_q);
          ptr_d    = ptr_inc;
          wv_d     = 1'b0;
          state_d  = (ptr_inc == dcnt_q) ? S_SHDN : S_PRD;
        end
      end

      S_SHDN: begin
        wv_d = 1'b0;
        if (wv_q) begin
          wr_en   = 1'b1;
          wr_addr = wa_q;
          wr_data = rd_data;
        end
        if (ptr_q != count_q) begin
          rd_en   = 1'b1;
          rd_addr = ptr_q[AW-1:0];
          ptr_d   = ptr_inc;
          wv_d    = 1'b1;
          wa_d    = ptr_sub[AW-1:0];
        end else if (!wv_q) begin
          count_d = count_q - dcnt_q;
          state_d = S_IDLE;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          out_st   = status_q;
          out_last = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      chk_v_q     <= 1'b0;
      wv_q        <= 1'b0;
      pfound_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      chk_v_q     <= chk_v_d;
      wv_q        <= wv_d;
      pfound_q    <= pfound_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    chk_pos_q <= chk_pos_d;
    wa_q      <= wa_d;
    pos_q     <= pos_d;
    dcnt_q    <= dcnt_d;
    status_q  <= status_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    src_q     <= src_d;
    if (out_load) begin
      status_o       <= out_st;
      out_index_o    <= out_ent.index;
      out_source_o   <= out_ent.source;
      out_deadline_o <= out_ent.deadline;
      last_o         <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready high right after an accepted beat");

  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DUE) |-> last_o)
    else $error("non-due result without last");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_SCAN || $past(state_q) == S_SHDN))
    else $error("entry count changed outside insert or pop");

endmodule
